// File: hw/rtl/omca_pkg.sv
package omca_pkg;

  // Default configuration of the tree
  localparam int TREE_DEPTH_DEF = 4;
  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KIND_COUNT_DEF = 6;

  // Operation codes carried in the request word
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Reply kinds
  localparam logic REPLY_LEAF   = 1'b0;
  localparam logic REPLY_CENTRE = 1'b1;

  // Divider / reply stage states
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_e;

  // Request word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  particle_kind;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
    logic [2:0]  query_level;
    logic [11:0] query_node;
  } req_t;

  // Response word
  typedef struct packed {
    logic        reply_kind;
    logic [11:0] leaf_index;
    logic [15:0] member_count;
    logic [15:0] centre_x;
    logic [15:0] centre_y;
    logic [15:0] centre_z;
    logic        node_empty;
  } rsp_t;

  // Control travelling along the chain of level cells
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic [2:0] kind;
  } ctl_t;

endpackage

// File: hw/rtl/octree_mass_centre_accumulator.sv
// Octree centre-of-mass accumulator.
// Requests arrive on req (req_valid/req_ready); replies leave on rsp
// (rsp_valid/rsp_ready). An add walks the root-to-leaf path, updating the
// count and coordinate sums of the particle kind in every node, and replies
// with the leaf index. A remove walks the same path and gives no reply. A
// query returns one node's count and truncated mean position.
// One word is in the tree at a time. Each tree level is a cell with its own
// memory that registers the word while its entry is read: an add passes the
// request register, every level cell, the divider stage and the output
// register. A query of a non-empty node also runs the restoring divider that
// forms the means, one bit of the coordinate sum (COORD_BITS+COUNT_BITS bits)
// per cycle. A new request is taken as soon as the previous reply has moved
// into the output register, or once a word without a reply leaves the chain.
// After reset all level memories are swept to zero, one entry a cycle, over
// every address of the largest one; req_ready stays low until the sweep ends.
// While the receiver stalls, the reply is held in the output register, and
// a further finished reply waits in the divider stage.
module octree_mass_centre_accumulator #(
  parameter int TREE_DEPTH = omca_pkg::TREE_DEPTH_DEF,
  parameter int COORD_BITS = omca_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = omca_pkg::COUNT_BITS_DEF,
  parameter int KIND_COUNT = omca_pkg::KIND_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  omca_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output omca_pkg::rsp_t  rsp
);
  import omca_pkg::*;

  localparam int NW       = 3 * TREE_DEPTH;
  localparam int SW       = COORD_BITS + COUNT_BITS;
  localparam int MAXDEPTH = KIND_COUNT << (3 * TREE_DEPTH);
  localparam int CLRW     = $clog2(MAXDEPTH);

  logic                        clearing;
  logic [CLRW-1:0]             clear_addr;
  logic                        busy;
  logic                        accept;
  logic                        handoff;

  ctl_t                        sctl;
  logic [2:0][COORD_BITS-1:0]  coord;
  logic [2:0]                  qlevel;
  logic [11:0]                 qnode;

  ctl_t                        ch_ctl  [TREE_DEPTH+2];
  logic [2:0][COORD_BITS-1:0]  ch_lo   [TREE_DEPTH+2];
  logic [NW-1:0]               ch_node [TREE_DEPTH+2];
  logic [COUNT_BITS-1:0]       ch_cnt  [TREE_DEPTH+2];
  logic [2:0][SW-1:0]          ch_sum  [TREE_DEPTH+2];

  logic                        div_done;
  logic                        div_drop;
  rsp_t                        div_result;

  assign accept    = req_valid && req_ready;
  assign req_ready = !clearing && !busy;
  assign handoff   = div_done && (!rsp_valid || rsp_ready);

  // Sweep the level memories after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == CLRW'(MAXDEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Track the word in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (handoff || div_drop) begin
      busy <= 1'b0;
    end
  end

  // Launch the word into the chain and hold its fields for every level
  always_ff @(posedge clk) begin
    if (rst) begin
      sctl <= '0;
    end else begin
      sctl.valid <= accept;
      sctl.op    <= req.opcode;
      sctl.kind  <= req.particle_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coord[0] <= COORD_BITS'(req.coord_x);
      coord[1] <= COORD_BITS'(req.coord_y);
      coord[2] <= COORD_BITS'(req.coord_z);
      qlevel   <= req.query_level;
      qnode    <= req.query_node;
    end
  end

  assign ch_ctl[0]  = sctl;
  assign ch_lo[0]   = '0;
  assign ch_node[0] = '0;
  assign ch_cnt[0]  = '0;
  assign ch_sum[0]  = '0;

  // One cell per tree level
  for (genvar l = 0; l <= TREE_DEPTH; l++) begin : g_level
    omca_cell #(
      .LEVEL      (l),
      .TREE_DEPTH (TREE_DEPTH),
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS),
      .KIND_COUNT (KIND_COUNT),
      .CLRW       (CLRW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .clear_en   (clearing),
      .clear_addr (clear_addr),
      .coord      (coord),
      .qlevel     (qlevel),
      .qnode      (qnode),
      .ctl_i      (ch_ctl[l]),
      .lo_i       (ch_lo[l]),
      .node_i     (ch_node[l]),
      .cnt_i      (ch_cnt[l]),
      .sum_i      (ch_sum[l]),
      .ctl_o      (ch_ctl[l+1]),
      .lo_o       (ch_lo[l+1]),
      .node_o     (ch_node[l+1]),
      .cnt_o      (ch_cnt[l+1]),
      .sum_o      (ch_sum[l+1])
    );
  end

  omca_div #(
    .TREE_DEPTH (TREE_DEPTH),
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .KIND_COUNT (KIND_COUNT)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ch_ctl[TREE_DEPTH+1]),
    .node   (ch_node[TREE_DEPTH+1]),
    .cnt    (ch_cnt[TREE_DEPTH+1]),
    .sum    (ch_sum[TREE_DEPTH+1]),
    .take   (handoff),
    .done   (div_done),
    .drop   (div_drop),
    .result (div_result)
  );

  // Output register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (handoff) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      rsp <= div_result;
    end
  end

endmodule

// File: hw/rtl/omca_ram.sv
module omca_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/omca_cell.sv
module omca_cell #(
  parameter int LEVEL      = 0,
  parameter int TREE_DEPTH = 4,
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16,
  parameter int KIND_COUNT = 6,
  parameter int CLRW       = 8,
  localparam int NW        = 3 * TREE_DEPTH,
  localparam int SW        = COORD_BITS + COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear_en,
  input  logic [CLRW-1:0]                  clear_addr,
  input  logic [2:0][COORD_BITS-1:0]       coord,
  input  logic [2:0]                       qlevel,
  input  logic [11:0]                      qnode,
  input  omca_pkg::ctl_t                   ctl_i,
  input  logic [2:0][COORD_BITS-1:0]       lo_i,
  input  logic [NW-1:0]                    node_i,
  input  logic [COUNT_BITS-1:0]            cnt_i,
  input  logic [2:0][SW-1:0]               sum_i,
  output omca_pkg::ctl_t                   ctl_o,
  output logic [2:0][COORD_BITS-1:0]       lo_o,
  output logic [NW-1:0]                    node_o,
  output logic [COUNT_BITS-1:0]            cnt_o,
  output logic [2:0][SW-1:0]               sum_o
);
  import omca_pkg::*;

  localparam int DEPTH = KIND_COUNT << (3 * LEVEL);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = 3 + NW;
  localparam int EW    = COUNT_BITS + 3 * SW;
  localparam logic [NW-1:0] QMASK = NW'((64'(1) << (3 * LEVEL)) - 64'(1));
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COORD_BITS-1:0] HALF =
    (LEVEL < TREE_DEPTH) ? COORD_BITS'(64'(1) << (COORD_BITS - LEVEL - 1)) : '0;

  logic                  kind_ok;
  logic                  is_query;
  logic [NW-1:0]         nsel;
  logic [FW-1:0]         afull;
  logic [AW-1:0]         raddr_c;

  ctl_t                        rctl;
  logic [2:0][COORD_BITS-1:0]  rlo;
  logic [NW-1:0]               rnode;
  logic [COUNT_BITS-1:0]       rcnt;
  logic [2:0][SW-1:0]          rsum;
  logic [AW-1:0]               raddr;
  logic                        rhit;
  logic                        rkind_ok;

  logic [EW-1:0]               rdata;
  logic [COUNT_BITS-1:0]       ecnt;
  logic [2:0][SW-1:0]          esum;
  logic [COUNT_BITS-1:0]       ncnt;
  logic [2:0][SW-1:0]          nsum;
  logic                        touch;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [EW-1:0]               wdata;
  logic [2:0]                  child;

  // Form the read address from the word arriving at this level
  always_comb begin
    kind_ok  = ({1'b0, ctl_i.kind} < 4'(KIND_COUNT));
    is_query = (ctl_i.op == OP_QUERY);
    nsel     = is_query ? (NW'(qnode) & QMASK) : node_i;
    afull    = (FW'(ctl_i.kind) << (3 * LEVEL)) | FW'(nsel);
    raddr_c  = afull[AW-1:0];
  end

  // Register the word while the entry is read
  always_ff @(posedge clk) begin
    if (rst) begin
      rctl <= '0;
    end else begin
      rctl <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rlo      <= lo_i;
    rnode    <= node_i;
    rcnt     <= cnt_i;
    rsum     <= sum_i;
    raddr    <= raddr_c;
    rkind_ok <= kind_ok;
    rhit     <= is_query && kind_ok && (qlevel == 3'(LEVEL));
  end

  // Update the entry for an add or a remove
  always_comb begin
    {ecnt, esum} = rdata;
    ncnt = ecnt;
    nsum = esum;
    if (rctl.op == OP_ADD) begin
      if (ecnt != CNT_MAX) begin
        ncnt = ecnt + 1'b1;
        for (int a = 0; a < 3; a++) begin
          nsum[a] = esum[a] + SW'(coord[a]);
        end
      end
    end else if (ecnt != '0) begin
      ncnt = ecnt - 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (ecnt == COUNT_BITS'(1)) begin
          nsum[a] = '0;
        end else if (esum[a] > SW'(coord[a])) begin
          nsum[a] = esum[a] - SW'(coord[a]);
        end else begin
          nsum[a] = '0;
        end
      end
    end
  end

  // Select the write: clearing sweep or path update
  always_comb begin
    touch = rctl.valid && rkind_ok && ((rctl.op == OP_ADD) || (rctl.op == OP_REMOVE));
    if (clear_en) begin
      we    = ({1'b0, clear_addr} < (CLRW + 1)'(DEPTH));
      waddr = clear_addr[AW-1:0];
      wdata = '0;
    end else begin
      we    = touch;
      waddr = raddr;
      wdata = {ncnt, nsum};
    end
  end

  omca_ram #(
    .W     (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  // Choose the child cell and hand the word on
  always_comb begin
    lo_o  = rlo;
    child = '0;
    if (LEVEL < TREE_DEPTH) begin
      for (int a = 0; a < 3; a++) begin
        if (coord[a] > (rlo[a] | HALF)) begin
          child[a] = 1'b1;
          lo_o[a]  = rlo[a] | HALF;
        end
      end
      node_o = (rnode << 3) | NW'(child);
    end else begin
      node_o = rnode;
    end
    ctl_o = rctl;
    cnt_o = rhit ? ecnt : rcnt;
    sum_o = rhit ? esum : rsum;
  end

endmodule

// File: hw/rtl/omca_div.sv
module omca_div #(
  parameter int TREE_DEPTH = 4,
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16,
  parameter int KIND_COUNT = 6,
  localparam int NW        = 3 * TREE_DEPTH,
  localparam int SW        = COORD_BITS + COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  omca_pkg::ctl_t        ctl,
  input  logic [NW-1:0]         node,
  input  logic [COUNT_BITS-1:0] cnt,
  input  logic [2:0][SW-1:0]    sum,
  input  logic                  take,
  output logic                  done,
  output logic                  drop,
  output omca_pkg::rsp_t        result
);
  import omca_pkg::*;

  localparam int SCW = $clog2(SW);

  div_state_e              state, state_next;
  logic                    kind_ok;
  logic                    add_ok;
  logic                    is_query;
  logic                    empty_q;

  logic                    rkind;
  logic [NW-1:0]           leaf;
  logic [COUNT_BITS-1:0]   divisor;
  logic                    empty;
  logic [SCW-1:0]          step;
  logic [2:0][SW-1:0]      dvd;
  logic [2:0][COUNT_BITS-1:0] rem;
  logic [2:0][SW-1:0]      dvd_next;
  logic [2:0][COUNT_BITS-1:0] rem_next;
  logic [COUNT_BITS:0]     trial;
  logic [2:0][15:0]        centre;

  always_comb begin
    kind_ok  = ({1'b0, ctl.kind} < 4'(KIND_COUNT));
    add_ok   = ctl.valid && (ctl.op == OP_ADD) && kind_ok;
    is_query = ctl.valid && (ctl.op == OP_QUERY);
    empty_q  = (cnt == '0);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: begin
        if (add_ok || (is_query && empty_q)) begin
          state_next = DV_DONE;
        end else if (is_query) begin
          state_next = DV_RUN;
        end
      end
      DV_RUN: begin
        if (step == SCW'(SW - 1)) begin
          state_next = DV_DONE;
        end
      end
      DV_DONE: begin
        if (take) begin
          state_next = DV_IDLE;
        end
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs
  always_comb begin
    done = (state == DV_DONE);
    drop = (state == DV_IDLE) && ctl.valid && !add_ok && !is_query;
  end

  // One restoring step on each axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      trial       = {rem[a], dvd[a][SW-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_next[a] = COUNT_BITS'(trial - {1'b0, divisor});
        dvd_next[a] = {dvd[a][SW-2:0], 1'b1};
      end else begin
        rem_next[a] = trial[COUNT_BITS-1:0];
        dvd_next[a] = {dvd[a][SW-2:0], 1'b0};
      end
    end
  end

  // Load on arrival, shift while dividing
  always_ff @(posedge clk) begin
    if (state == DV_IDLE) begin
      rkind   <= is_query ? REPLY_CENTRE : REPLY_LEAF;
      leaf    <= is_query ? '0 : node;
      divisor <= is_query ? cnt : '0;
      empty   <= is_query && empty_q;
      step    <= '0;
      rem     <= '0;
      dvd     <= (is_query && !empty_q) ? sum : '0;
    end else if (state == DV_RUN) begin
      step <= step + 1'b1;
      rem  <= rem_next;
      dvd  <= dvd_next;
    end
  end

  // Saturate the means and build the reply
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (|dvd[a][SW-1:COORD_BITS]) begin
        centre[a] = 16'({COORD_BITS{1'b1}});
      end else begin
        centre[a] = 16'(dvd[a][COORD_BITS-1:0]);
      end
    end
    result.reply_kind   = rkind;
    result.leaf_index   = 12'(leaf);
    result.member_count = 16'(divisor);
    result.centre_x     = centre[0];
    result.centre_y     = centre[1];
    result.centre_z     = centre[2];
    result.node_empty   = empty;
  end

endmodule

// File: sim/octree_mass_centre_accumulator_tb.sv
`timescale 1ns / 1ps

module octree_mass_centre_accumulator_tb;
  import omca_pkg::*;

  localparam int DEPTH      = TREE_DEPTH_DEF;
  localparam int KINDS      = KIND_COUNT_DEF;
  localparam int NODES      = ((1 << (3 * (DEPTH + 1))) - 1) / 7;
  localparam int SLOTS      = KINDS * NODES;
  localparam int COUNT_FULL = (1 << COUNT_BITS_DEF) - 1;
  localparam int COORD_TOP  = (1 << COORD_BITS_DEF) - 1;
  localparam int STALL_LIMIT = 100000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  octree_mass_centre_accumulator uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Shadow of the tree: per kind and node, a count and three sums
  int unsigned    node_count [SLOTS];
  longint unsigned node_sum_x [SLOTS];
  longint unsigned node_sum_y [SLOTS];
  longint unsigned node_sum_z [SLOTS];

  req_t pending_words[$];
  rsp_t expected_replies[$];
  int   mismatches;
  int   idle_cycles;
  bit   stimulus_done;
  bit   drain_hold;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int level_base(int lvl);
    return ((1 << (3 * lvl)) - 1) / 7;
  endfunction

  function automatic longint unsigned sub_floor(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic longint unsigned mean_clamped(longint unsigned s, int unsigned n);
    longint unsigned q;
    q = s / n;
    return (q > COORD_TOP) ? COORD_TOP : q;
  endfunction

  // Update one node on the path of an add or a remove
  task automatic update_node(int slot, longint unsigned cx, longint unsigned cy,
                             longint unsigned cz, bit adding);
    if (adding) begin
      if (node_count[slot] >= COUNT_FULL) return;
      node_count[slot]++;
      node_sum_x[slot] += cx;
      node_sum_y[slot] += cy;
      node_sum_z[slot] += cz;
    end else begin
      if (node_count[slot] == 0) return;
      node_count[slot]--;
      if (node_count[slot] == 0) begin
        node_sum_x[slot] = 0;
        node_sum_y[slot] = 0;
        node_sum_z[slot] = 0;
      end else begin
        node_sum_x[slot] = sub_floor(node_sum_x[slot], cx);
        node_sum_y[slot] = sub_floor(node_sum_y[slot], cy);
        node_sum_z[slot] = sub_floor(node_sum_z[slot], cz);
      end
    end
  endtask

  // Advance the shadow tree by one accepted word and queue its reply, if it has one
  task automatic predict_tree_word(req_t w);
    longint unsigned c[3];
    longint unsigned lo[3];
    longint unsigned half;
    int   node;
    int   child;
    int   slot;
    int   lvl;
    int unsigned n;
    rsp_t r;
    c[0] = w.coord_x;
    c[1] = w.coord_y;
    c[2] = w.coord_z;
    r = '0;
    if (w.opcode == OP_ADD || w.opcode == OP_REMOVE) begin
      if (w.particle_kind >= KINDS) return;
      lo = '{0, 0, 0};
      node = 0;
      for (lvl = 0; lvl <= DEPTH; lvl++) begin
        update_node(w.particle_kind * NODES + level_base(lvl) + node,
                    c[0], c[1], c[2], w.opcode == OP_ADD);
        if (lvl < DEPTH) begin
          half = 64'd1 << (COORD_BITS_DEF - lvl - 1);
          child = 0;
          for (int a = 0; a < 3; a++) begin
            if (c[a] > lo[a] + half) begin
              child |= 1 << a;
              lo[a] += half;
            end
          end
          node = (node << 3) | child;
        end
      end
      if (w.opcode == OP_REMOVE) return;
      r.reply_kind = REPLY_LEAF;
      r.leaf_index = node[11:0];
      expected_replies.push_back(r);
    end else if (w.opcode == OP_QUERY) begin
      r.reply_kind = REPLY_CENTRE;
      n = 0;
      slot = 0;
      if (w.particle_kind < KINDS && w.query_level <= DEPTH) begin
        node = w.query_node & ((1 << (3 * w.query_level)) - 1);
        slot = w.particle_kind * NODES + level_base(w.query_level) + node;
        n = node_count[slot];
      end
      if (n == 0) begin
        r.node_empty = 1'b1;
      end else begin
        r.member_count = n[15:0];
        r.centre_x = 16'(mean_clamped(node_sum_x[slot], n));
        r.centre_y = 16'(mean_clamped(node_sum_y[slot], n));
        r.centre_z = 16'(mean_clamped(node_sum_z[slot], n));
      end
      expected_replies.push_back(r);
    end
  endtask

  function automatic int gap_length();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 25);
  endfunction

  function automatic req_t make_word(logic [1:0] op, logic [2:0] kind, logic [15:0] x,
                                     logic [15:0] y, logic [15:0] z, logic [2:0] lvl,
                                     logic [11:0] nd);
    req_t w;
    w.opcode = op;
    w.particle_kind = kind;
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    w.query_level = lvl;
    w.query_node = nd;
    return w;
  endfunction

  // Note whether the word on offer was taken at the last rising edge
  bit req_taken;
  always @(posedge clk) begin
    req_taken = req_valid && req_ready;
  end

  // Driver: present words at the falling edge, with random gaps
  int gap_left;
  initial gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // hold
    end else begin
      if (req_valid) gap_left = gap_length();
      if (gap_left > 0 || drain_hold || pending_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        req_valid <= 1'b0;
      end else begin
        req <= pending_words.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // Receiver stalls at random, with stretches of steady readiness
  int stall_mode;
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_mode = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          rsp_ready <= 1'b1;
        end
        1: begin
          rsp_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          rsp_ready <= ($urandom_range(0, 19) == 0);
        end
      endcase
    end
  end

  // Monitor: predict on accepted requests, compare accepted replies
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (req_valid && req_ready) predict_tree_word(req);
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reply %p", rsp);
        end else begin
          rsp_t e;
          e = expected_replies.pop_front();
          if (e !== rsp) begin
            mismatches++;
            if (mismatches <= 10) $display("reply wrong: expected %p, got %p", e, rsp);
          end
        end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("octree_mass_centre_accumulator: mismatch");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] px, py, pz;
    logic [2:0]  k;
    int          roll;
    mismatches = 0;
    stimulus_done = 0;
    drain_hold = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    rsp_ready = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, midpoints, all operations and odd cases
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_ADD, 3'd0, 16'h0000, 16'h0000, 16'h0000, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_ADD, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 12'hFFF));
    pending_words.push_back(make_word(OP_ADD, 3'd5, 16'h8000, 16'h8001, 16'h4000, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 12'hFFF));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd4, 12'hFFF));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd4, 12'h000));
    pending_words.push_back(make_word(OP_QUERY, 3'd6, 16'd0, 16'd0, 16'd0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd7, 16'd0, 16'd0, 16'd0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd5, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd7, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd1, 12'hFF8));
    pending_words.push_back(make_word(OP_ADD, 3'd6, 16'h1234, 16'h1, 16'h2, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_REMOVE, 3'd7, 16'h1234, 16'h1, 16'h2, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_UNUSED, 3'd0, 16'hFFFF, 16'h0, 16'h0, 3'd0, 12'd0));
    // a remove of the 16'hFFFF corner clears the root sums, then a remove empties the root
    pending_words.push_back(make_word(OP_REMOVE, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_REMOVE, 3'd0, 16'h0, 16'h0, 16'h0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd0, 16'd0, 16'd0, 16'd0, 3'd0, 12'd0));
    // remove from an empty node
    pending_words.push_back(make_word(OP_REMOVE, 3'd2, 16'h5555, 16'hAAAA, 16'h0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd2, 16'd0, 16'd0, 16'd0, 3'd0, 12'd0));
    pending_words.push_back(make_word(OP_QUERY, 3'd5, 16'd0, 16'd0, 16'd0, 3'd2, 12'o17));

    // Pause the sender until every reply is home
    wait (pending_words.size() == 0 && !req_valid);
    drain_hold = 1;
    wait (expected_replies.size() == 0);
    repeat (50) @(posedge clk);
    drain_hold = 0;

    // Random: mostly adds and removes, partly clustered, with queries, unused opcodes and bad kinds
    for (int i = 0; i < 1030; i++) begin
      k = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      px = $urandom_range(0, 9) < 3 ? 16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 2))
                                    : 16'($urandom);
      py = $urandom_range(0, 9) < 3 ? 16'h8000 : 16'($urandom);
      pz = $urandom_range(0, 9) < 2 ? 16'hFFFF : 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 45)
        pending_words.push_back(make_word(OP_ADD, k, px, py, pz, 3'($urandom), 12'($urandom)));
      else if (roll < 60)
        pending_words.push_back(make_word(OP_REMOVE, k, px, py, pz, 3'($urandom),
                                          12'($urandom)));
      else if (roll < 97)
        pending_words.push_back(make_word(OP_QUERY, k, px, py, pz,
                                          $urandom_range(0, 9) == 0 ? 3'($urandom)
                                                                    : 3'($urandom_range(0, 2)),
                                          $urandom_range(0, 1) ? 12'($urandom)
                                                               : 12'($urandom_range(0, 63))));
      else
        pending_words.push_back(make_word(OP_UNUSED, k, px, py, pz, 3'($urandom), 12'($urandom)));
    end

    // Drain and settle
    wait (pending_words.size() == 0 && !req_valid);
    wait (expected_replies.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("octree_mass_centre_accumulator: match");
    end else begin
      $display("octree_mass_centre_accumulator: mismatch");
    end
    $finish;
  end

endmodule
